FILE: rtl/plr_pkg.sv
// Package for the PCX RLE line decoder: shared constants, error codes and the
// command type passed from the front end to the expander. No dependencies.
`default_nettype none
package plr_pkg;

    localparam int DIM_BITS_DEF = 15;
    localparam int CMD_DEPTH    = 4;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int RUN_LEN_W    = 6;

    localparam logic [1:0] RUN_MARK = 2'b11;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LINE   = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_CFG  = 2'd1;
    localparam logic [1:0] ERR_RUN  = 2'd2;

    typedef struct packed {
        logic [7:0]           pixel;
        logic [RUN_LEN_W-1:0] count;
        logic [1:0]           err;
        logic                 last_row;
    } t_cmd_ctl;

endpackage
`default_nettype wire

FILE: rtl/pcx_rle_line_decoder.sv
// Top level of the 8-bpp PCX RLE line decoder: configuration registers and
// wiring of front end, command queue and run expander. Depends on plr_pkg.
//
// Usage: one compressed byte is taken per cycle while the command queue
// (four entries) has room; the expander then emits one result per cycle
// while its output register is empty or popped, so a run of n pixels
// gives n results, and input stalls once the queue fills. Run headers,
// zero-count runs and padding bytes produce no result. Registers sit at
// byte addresses 0 (width), 4 (height) and 8 (bytes per line); write them
// only while no transaction is in flight.
`default_nettype none
module pcx_rle_line_decoder #(
    parameter int DIM_BITS = plr_pkg::DIM_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [plr_pkg::PADDR_W-1:0] paddr,
    input  wire  [plr_pkg::PDATA_W-1:0] pwdata,
    output logic [plr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  wire                         push,
    output logic                        full,
    input  wire  [7:0]                  i_data_byte,
    output logic                        empty,
    input  wire                         pop,
    output logic [7:0]                  o_pixel,
    output logic                        o_last_in_run,
    output logic                        o_row_end,
    output logic                        o_image_end,
    output logic [1:0]                  o_error_code
);

    localparam int CMD_W = $bits(plr_pkg::t_cmd_ctl) + DIM_BITS;

    logic [DIM_BITS-1:0] r_width, r_height, r_line_bytes;
    logic [1:0]          reg_idx;
    logic                cfg_wr;

    plr_pkg::t_cmd_ctl   wr_ctl, rd_ctl;
    logic [DIM_BITS-1:0] wr_col, rd_col;
    logic [CMD_W-1:0]    rd_data;
    logic                cmd_wr, cmd_rd, cmd_empty;

    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            plr_pkg::REG_WIDTH:  prdata = plr_pkg::PDATA_W'(r_width);
            plr_pkg::REG_HEIGHT: prdata = plr_pkg::PDATA_W'(r_height);
            plr_pkg::REG_LINE:   prdata = plr_pkg::PDATA_W'(r_line_bytes);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= DIM_BITS'(1);
            r_height     <= DIM_BITS'(1);
            r_line_bytes <= DIM_BITS'(1);
        end else if (cfg_wr) begin
            case (reg_idx)
                plr_pkg::REG_WIDTH:  r_width      <= pwdata[DIM_BITS-1:0];
                plr_pkg::REG_HEIGHT: r_height     <= pwdata[DIM_BITS-1:0];
                plr_pkg::REG_LINE:   r_line_bytes <= pwdata[DIM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    plr_front #(.DIM_BITS(DIM_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_data_byte  (i_data_byte),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_line_bytes (r_line_bytes),
        .o_cmd_wr     (cmd_wr),
        .o_cmd_ctl    (wr_ctl),
        .o_cmd_col    (wr_col)
    );

    plr_cmd_fifo #(.DATA_W(CMD_W), .DEPTH(plr_pkg::CMD_DEPTH)) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata ({wr_ctl, wr_col}),
        .i_rd    (cmd_rd),
        .o_rdata (rd_data),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    assign rd_ctl = rd_data[CMD_W-1:DIM_BITS];
    assign rd_col = rd_data[DIM_BITS-1:0];

    plr_back #(.DIM_BITS(DIM_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_empty   (cmd_empty),
        .i_cmd_ctl     (rd_ctl),
        .i_cmd_col     (rd_col),
        .o_cmd_rd      (cmd_rd),
        .i_width       (r_width),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pixel       (o_pixel),
        .o_last_in_run (o_last_in_run),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end),
        .o_error_code  (o_error_code)
    );

endmodule
`default_nettype wire

FILE: rtl/plr_front.sv
// Front end: accepts compressed bytes, tracks run/column/row state and issues
// one command per pixel group or error. Depends on plr_pkg.
`default_nettype none
module plr_front #(
    parameter int DIM_BITS = plr_pkg::DIM_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire                  i_full,
    input  wire [7:0]            i_data_byte,
    input  wire [DIM_BITS-1:0]   i_width,
    input  wire [DIM_BITS-1:0]   i_height,
    input  wire [DIM_BITS-1:0]   i_line_bytes,
    output logic                 o_cmd_wr,
    output plr_pkg::t_cmd_ctl    o_cmd_ctl,
    output logic [DIM_BITS-1:0]  o_cmd_col
);

    logic                           r_run_pending, n_run_pending;
    logic [plr_pkg::RUN_LEN_W-1:0]  r_run_length,  n_run_length;
    logic [DIM_BITS-1:0]            r_column,      n_column;
    logic [DIM_BITS-1:0]            r_row,         n_row;
    logic                           r_finished,    n_finished;
    logic                           r_failed,      n_failed;

    logic                cfg_bad;
    logic [DIM_BITS:0]   run_sum;
    logic [DIM_BITS-1:0] col_adv;
    logic [DIM_BITS-1:0] row_inc;
    logic                do_adv;

    always_comb begin
        cfg_bad = (i_width == '0) || (i_height == '0) || (i_line_bytes == '0)
               || (i_line_bytes < i_width);
        run_sum = {1'b0, r_column} + {{(DIM_BITS + 1 - plr_pkg::RUN_LEN_W){1'b0}},
                                       r_run_length};
        row_inc = r_row + 1'b1;

        n_run_pending = r_run_pending;
        n_run_length  = r_run_length;
        n_column      = r_column;
        n_row         = r_row;
        n_finished    = r_finished;
        n_failed      = r_failed;
        do_adv        = 1'b0;
        col_adv       = r_column;

        o_cmd_wr           = 1'b0;
        o_cmd_col          = r_column;
        o_cmd_ctl.pixel    = i_data_byte;
        o_cmd_ctl.count    = plr_pkg::RUN_LEN_W'(1);
        o_cmd_ctl.err      = plr_pkg::ERR_NONE;
        o_cmd_ctl.last_row = ({1'b0, r_row} + 1'b1) == {1'b0, i_height};

        if (i_push && !i_full && !r_finished && !r_failed) begin
            if (cfg_bad) begin
                o_cmd_wr        = 1'b1;
                o_cmd_ctl.pixel = '0;
                o_cmd_ctl.err   = plr_pkg::ERR_CFG;
                n_failed        = 1'b1;
            end else if (r_run_pending) begin
                n_run_pending = 1'b0;
                n_run_length  = '0;
                if (run_sum > {1'b0, i_width}) begin
                    o_cmd_wr        = 1'b1;
                    o_cmd_ctl.pixel = '0;
                    o_cmd_ctl.err   = plr_pkg::ERR_RUN;
                    n_failed        = 1'b1;
                end else begin
                    o_cmd_wr        = (r_run_length != '0);
                    o_cmd_ctl.count = r_run_length;
                    col_adv         = run_sum[DIM_BITS-1:0];
                    do_adv          = 1'b1;
                end
            end else if (i_data_byte[7:6] == plr_pkg::RUN_MARK) begin
                n_run_pending = 1'b1;
                n_run_length  = i_data_byte[plr_pkg::RUN_LEN_W-1:0];
            end else begin
                o_cmd_wr = (r_column < i_width);
                col_adv  = r_column + 1'b1;
                do_adv   = 1'b1;
            end
        end

        if (do_adv) begin
            if (col_adv >= i_line_bytes) begin
                n_column = '0;
                n_row    = row_inc;
                if (row_inc >= i_height) begin
                    n_finished = 1'b1;
                end
            end else begin
                n_column = col_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pending <= 1'b0;
            r_run_length  <= '0;
            r_column      <= '0;
            r_row         <= '0;
            r_finished    <= 1'b0;
            r_failed      <= 1'b0;
        end else begin
            r_run_pending <= n_run_pending;
            r_run_length  <= n_run_length;
            r_column      <= n_column;
            r_row         <= n_row;
            r_finished    <= n_finished;
            r_failed      <= n_failed;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/plr_cmd_fifo.sv
// Short command queue between the front end and the run expander.
// Depends on plr_pkg for nothing but is sized by its caller.
`default_nettype none
module plr_cmd_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_wr,
    input  wire  [DATA_W-1:0] i_wdata,
    input  wire               i_rd,
    output logic [DATA_W-1:0] o_rdata,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_mcount, n_mcount;
    logic              r_valid, n_valid;
    logic              wr_en, rd_en, load;

    // r_count holds every entry, r_mcount only those still in r_mem; the head
    // entry sits in the registered output stage while r_valid is high
    always_comb begin
        o_full   = (r_count == CNT_W'(DEPTH));
        o_empty  = !r_valid;
        o_rdata  = r_rdata;
        wr_en    = i_wr && !o_full;
        rd_en    = i_rd && r_valid;
        load     = (r_mcount != '0) && (!r_valid || rd_en);
        n_wptr   = r_wptr;
        n_rptr   = r_rptr;
        n_valid  = r_valid;
        if (wr_en) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (load) begin
            n_rptr  = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            n_valid = 1'b1;
        end else if (rd_en) begin
            n_valid = 1'b0;
        end
        n_count  = r_count + CNT_W'(wr_en) - CNT_W'(rd_en);
        n_mcount = r_mcount + CNT_W'(wr_en) - CNT_W'(load);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
        if (load) begin
            r_rdata <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_count  <= '0;
            r_mcount <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_wptr   <= n_wptr;
            r_rptr   <= n_rptr;
            r_count  <= n_count;
            r_mcount <= n_mcount;
            r_valid  <= n_valid;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/plr_back.sv
// Run expander: expands queued commands, one result per cycle unless the
// output register holds an unpopped result. Depends on plr_pkg.
`default_nettype none
module plr_back #(
    parameter int DIM_BITS = plr_pkg::DIM_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cmd_empty,
    input  plr_pkg::t_cmd_ctl   i_cmd_ctl,
    input  wire  [DIM_BITS-1:0] i_cmd_col,
    output logic                o_cmd_rd,
    input  wire  [DIM_BITS-1:0] i_width,
    input  wire                 i_pop,
    output logic                o_empty,
    output logic [7:0]          o_pixel,
    output logic                o_last_in_run,
    output logic                o_row_end,
    output logic                o_image_end,
    output logic [1:0]          o_error_code
);

    logic [plr_pkg::RUN_LEN_W-1:0] r_idx, n_idx;
    logic                          r_valid;
    logic [7:0]                    r_pixel;
    logic                          r_last, r_rend, r_iend;
    logic [1:0]                    r_err;

    logic              advance;
    logic [DIM_BITS:0] col;
    logic              last, rend;

    always_comb begin
        advance  = !i_cmd_empty && (!r_valid || i_pop);
        col      = {1'b0, i_cmd_col}
                 + {{(DIM_BITS + 1 - plr_pkg::RUN_LEN_W){1'b0}}, r_idx};
        last     = (r_idx + 1'b1) == i_cmd_ctl.count;
        rend     = (i_cmd_ctl.err == plr_pkg::ERR_NONE)
                && ((col + 1'b1) == {1'b0, i_width});
        o_cmd_rd = advance && last;
        n_idx    = r_idx;
        if (advance) begin
            n_idx = last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pixel <= i_cmd_ctl.pixel;
            r_last  <= last;
            r_rend  <= rend;
            r_iend  <= rend && i_cmd_ctl.last_row;
            r_err   <= i_cmd_ctl.err;
        end
    end

    assign o_empty       = !r_valid;
    assign o_pixel       = r_pixel;
    assign o_last_in_run = r_last;
    assign o_row_end     = r_rend;
    assign o_image_end   = r_iend;
    assign o_error_code  = r_err;

endmodule
`default_nettype wire
